// ----- hw/rtl/address_crc_base64url_encoder_core_defines.svh -----
`ifndef ADDRESS_CRC_BASE64URL_ENCODER_CORE_DEFINES_SVH
`define ADDRESS_CRC_BASE64URL_ENCODER_CORE_DEFINES_SVH

// checks sampled on the rising clock edge, off while reset is high
`define ACBE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checks that also hold while reset is high
`define ACBE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/acbe_pkg.sv -----
package acbe_pkg;

   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [7:0]  TAG_BOUNCE   = 8'h11;
   localparam logic [7:0]  TAG_NOBOUNCE = 8'h51;
   localparam logic [7:0]  TAG_TESTNET  = 8'h80;
   localparam logic [7:0]  CHAIN_BASE   = 8'h00;
   localparam logic [7:0]  CHAIN_OTHER  = 8'hFF;
   localparam logic [4:0]  LAST_POS     = 5'd31;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNCEABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TESTNET_ONLY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OTHER_CHAIN  = 2'd2;

   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_LAST  = 2'd2;

   typedef struct packed {
      logic [7:0] char_a;
      logic [7:0] char_b;
      logic [7:0] char_c;
      logic [7:0] char_d;
      logic       last_group;
   } rsp_word_type;

   // msb-first crc-16 over one byte, eight shift steps unrolled
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] b64url_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = 8'h2D;
      end else begin
         ch = 8'h5F;
      end
      return ch;
   endfunction

   function automatic rsp_word_type make_word(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic last);
      rsp_word_type w;
      logic [23:0]  n;
      n = {b0, b1, b2};
      w.char_a     = b64url_char(n[23:18]);
      w.char_b     = b64url_char(n[17:12]);
      w.char_c     = b64url_char(n[11:6]);
      w.char_d     = b64url_char(n[5:0]);
      w.last_group = last;
      return w;
   endfunction

endpackage

// ----- hw/rtl/address_crc_base64url_encoder_core.sv -----
// a byte that closes a group has its word written to the output register, or to the skid register while rsp stalls
// throughput: one hash byte per cycle while req_stall is low, one word per three frame bytes, twelve words per address
// a byte crc step and the base64 mapping sit between the state and the output register
// a skid register behind the output register holds one word while rsp stalls, and req stalls once it is full
// synchronous reset: bounceable=1, testnet_only=0, other_chain=0, empty frame, no word held
`include "address_crc_base64url_encoder_core_defines.svh"

module address_crc_base64url_encoder_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_hash_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_char_a,
   output logic [7:0]                      rsp_char_b,
   output logic [7:0]                      rsp_char_c,
   output logic [7:0]                      rsp_char_d,
   output logic                            rsp_last_group,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [acbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                            csr_data
);
   import acbe_pkg::*;

   logic         bounceable_ff, bounceable_in;
   logic         testnet_ff, testnet_in;
   logic         other_chain_ff, other_chain_in;

   logic [4:0]   pos_ff, pos_in;
   logic [1:0]   phase_ff, phase_in;
   logic [15:0]  crc_ff, crc_in;
   logic [15:0]  held_ff, held_in;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   logic         accept, take, produce;
   logic [7:0]   tag, chain;
   logic [15:0]  crc_base, held_base, crc_new;
   rsp_word_type new_word;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;

   always_comb begin
      bounceable_in  = bounceable_ff;
      testnet_in     = testnet_ff;
      other_chain_in = other_chain_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOUNCEABLE:   bounceable_in  = csr_data;
            CSR_TESTNET_ONLY: testnet_in     = csr_data;
            CSR_OTHER_CHAIN:  other_chain_in = csr_data;
            default:          ;
         endcase
      end
   end

   // frame step for one hash byte
   always_comb begin
      tag       = (bounceable_ff ? TAG_BOUNCE : TAG_NOBOUNCE) | (testnet_ff ? TAG_TESTNET : 8'h00);
      chain     = other_chain_ff ? CHAIN_OTHER : CHAIN_BASE;
      crc_base  = (pos_ff == 5'd0) ? crc16_byte(crc16_byte(16'h0000, tag), chain) : crc_ff;
      held_base = (pos_ff == 5'd0) ? {tag, chain} : held_ff;
      crc_new   = crc16_byte(crc_base, req_hash_byte);

      produce  = 1'b0;
      new_word = make_word(held_base[15:8], held_base[7:0], req_hash_byte, 1'b0);
      pos_in   = pos_ff;
      phase_in = phase_ff;
      crc_in   = crc_ff;
      held_in  = held_ff;
      if (accept) begin
         crc_in   = crc_new;
         pos_in   = pos_ff + 5'd1;
         phase_in = (phase_ff == PHASE_LAST) ? PHASE_FIRST : phase_ff + 2'd1;
         if (phase_ff == PHASE_FIRST) begin
            produce = 1'b1;
            held_in = 16'h0000;
         end else if (pos_ff == LAST_POS) begin
            produce  = 1'b1;
            new_word = make_word(req_hash_byte, crc_new[15:8], crc_new[7:0], 1'b1);
            held_in  = 16'h0000;
            crc_in   = 16'h0000;
            phase_in = PHASE_FIRST;
         end else begin
            held_in = {held_base[7:0], req_hash_byte};
         end
      end
   end

   // output register with skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff && take) begin
         out_word_in   = skid_word_ff;
         skid_valid_in = 1'b0;
      end else if (produce) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_word_in  = new_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = new_word;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounceable_ff  <= 1'b1;
         testnet_ff     <= 1'b0;
         other_chain_ff <= 1'b0;
         pos_ff         <= 5'd0;
         phase_ff       <= PHASE_FIRST;
         crc_ff         <= 16'h0000;
         held_ff        <= 16'h0000;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         bounceable_ff  <= bounceable_in;
         testnet_ff     <= testnet_in;
         other_chain_ff <= other_chain_in;
         pos_ff         <= pos_in;
         phase_ff       <= phase_in;
         crc_ff         <= crc_in;
         held_ff        <= held_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_a     = out_word_ff.char_a;
   assign rsp_char_b     = out_word_ff.char_b;
   assign rsp_char_c     = out_word_ff.char_c;
   assign rsp_char_d     = out_word_ff.char_d;
   assign rsp_last_group = out_word_ff.last_group;

   `ACBE_ASSERT(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid full while output empty")
   `ACBE_ASSERT(a_addr_end_clears, accept && pos_ff == LAST_POS |=> pos_ff == 5'd0 && crc_ff == 16'h0000 && held_ff == 16'h0000 && phase_ff == PHASE_FIRST, "address end did not clear frame state")
   `ACBE_ASSERT(a_pos_steps, accept && pos_ff != LAST_POS |=> pos_ff == $past(pos_ff) + 5'd1, "byte position did not advance")
   `ACBE_ASSERT(a_group_clears_held, accept && phase_ff == PHASE_FIRST |=> held_ff == 16'h0000, "held bytes not cleared after a group")

endmodule

// ----- dv/address_crc_base64url_encoder_core_test.sv -----
module address_crc_base64url_encoder_core_test;
   import acbe_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 90;
   localparam int REGIME_ITEMS = 480;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [0:63][7:0] B64URL_SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_hash_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_char_a;
   logic [7:0] rsp_char_b;
   logic [7:0] rsp_char_c;
   logic [7:0] rsp_char_d;
   logic rsp_last_group;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic csr_data = 1'b0;

   address_crc_base64url_encoder_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_hash_byte(req_hash_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_a(rsp_char_a),
      .rsp_char_b(rsp_char_b),
      .rsp_char_c(rsp_char_c),
      .rsp_char_d(rsp_char_d),
      .rsp_last_group(rsp_last_group),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // address settings as the encoder should hold them
   logic addr_bounceable = 1'b1;
   logic addr_testnet = 1'b0;
   logic addr_other_chain = 1'b0;

   // frame state of the address being encoded
   logic [4:0] frame_pos = '0;
   logic [15:0] frame_crc = '0;
   logic [15:0] frame_held = '0;

   logic [7:0] hash_backlog[$];
   rsp_word_type expected_groups[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asked = 0;
   int hold_granted = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   logic hash_taken = 1'b0;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         if (c[15] ^ data[i]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic rsp_word_type encode_group(input logic [23:0] bits, input logic last);
      rsp_word_type w;
      w.char_a = B64URL_SYMBOLS[bits[23:18]];
      w.char_b = B64URL_SYMBOLS[bits[17:12]];
      w.char_c = B64URL_SYMBOLS[bits[11:6]];
      w.char_d = B64URL_SYMBOLS[bits[5:0]];
      w.last_group = last;
      return w;
   endfunction

   task automatic frame_hash_byte(input logic [7:0] b);
      logic [7:0] tag;
      logic [7:0] chain;
      if (frame_pos == 5'd0) begin
         tag = addr_bounceable ? TAG_BOUNCE : TAG_NOBOUNCE;
         if (addr_testnet) begin
            tag = tag | TAG_TESTNET;
         end
         chain = addr_other_chain ? CHAIN_OTHER : CHAIN_BASE;
         frame_crc = crc_step(crc_step(16'h0000, tag), chain);
         frame_held = {tag, chain};
      end
      frame_crc = crc_step(frame_crc, b);
      if (frame_pos % 3 == 0) begin
         expected_groups.push_back(encode_group({frame_held, b}, 1'b0));
         frame_held = '0;
      end else if (frame_pos == LAST_POS) begin
         expected_groups.push_back(encode_group({b, frame_crc}, 1'b1));
         frame_held = '0;
         frame_crc = '0;
      end else begin
         frame_held = {frame_held[7:0], b};
      end
      frame_pos = frame_pos + 5'd1;
   endtask

   // hash byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || hash_taken) begin
         if (hash_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_hash_byte <= hash_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
            req_hash_byte <= 8'($urandom);
         end
      end
   end

   // result receiver, long hold-offs counted here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_granted != hold_asked) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_granted <= hold_granted + 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         hash_taken <= 1'b0;
      end else begin
         hash_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_char_a, rsp_char_b, rsp_char_c, rsp_char_d, rsp_last_group};
            if (expected_groups.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected word: %c%c%c%c last=%0b", got.char_a, got.char_b,
                           got.char_c, got.char_d, got.last_group);
               end
            end else begin
               want = expected_groups.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("word mismatch: expected %c%c%c%c last=%0b, got %c%c%c%c last=%0b",
                              want.char_a, want.char_b, want.char_c, want.char_d,
                              want.last_group, got.char_a, got.char_b, got.char_c,
                              got.char_d, got.last_group);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            frame_hash_byte(req_hash_byte);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout");
         $display("** address_crc_base64url_encoder_core: FAILED **");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BOUNCEABLE) begin
         addr_bounceable = val;
      end else if (idx == CSR_TESTNET_ONLY) begin
         addr_testnet = val;
      end else if (idx == CSR_OTHER_CHAIN) begin
         addr_other_chain = val;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (hash_backlog.size() != 0 || req_valid || expected_groups.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_setting(input int k);
      write_csr(CSR_BOUNCEABLE, k[0]);
      write_csr(CSR_TESTNET_ONLY, k[1]);
      write_csr(CSR_OTHER_CHAIN, k[2]);
      if (k % 2 == 1) begin
         write_csr(CSR_UNUSED, 1'($urandom_range(1, 0)));
      end
   endtask

   initial begin
      logic [7:0] opening[12];
      logic [7:0] closing[12];
      int setting_count;
      int sent;
      int n;
      opening = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'hEF, 8'hBE,
                  8'h00, 8'h00, 8'h00, 8'h55, 8'hAA};
      closing = '{8'h0F, 8'hF0, 8'h01, 8'h80, 8'h7F, 8'hFE,
                  8'h10, 8'h20, 8'h40, 8'h08, 8'h04, 8'h02};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // reset settings, then a change in the middle of the address
      foreach (opening[i]) hash_backlog.push_back(opening[i]);
      wait_drained();
      write_csr(CSR_BOUNCEABLE, 1'b0);
      write_csr(CSR_TESTNET_ONLY, 1'b1);
      write_csr(CSR_OTHER_CHAIN, 1'b1);
      write_csr(CSR_UNUSED, 1'b0);
      foreach (closing[i]) hash_backlog.push_back(closing[i]);

      setting_count = 0;
      for (int regime = 0; regime < 3; regime++) begin
         if (regime == 0) begin
            send_idle_pct = 32;
            recv_stall_pct = 53;
         end else if (regime == 1) begin
            send_idle_pct = 53;
            recv_stall_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         sent = 0;
         while (sent < REGIME_ITEMS) begin
            wait_drained();
            apply_setting(setting_count);
            setting_count++;
            if (sent == 0 && regime != 1) begin
               n = 200;
               hold_asked = hold_asked + 1;
            end else begin
               n = $urandom_range(120, 15);
            end
            repeat (n) hash_backlog.push_back(8'($urandom));
            sent += n;
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** address_crc_base64url_encoder_core: PASSED **");
      end else begin
         $display("** address_crc_base64url_encoder_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- address_crc_base64url_encoder_core.f -----
+incdir+hw/rtl
hw/rtl/acbe_pkg.sv
hw/rtl/address_crc_base64url_encoder_core.sv
dv/address_crc_base64url_encoder_core_test.sv
